FILE: sv/ssh_df_pkg.sv
// ----------------------------------------------------------------------------
// ssh_df_pkg
// Shared types and constants for the ssh packet deframer.
// ----------------------------------------------------------------------------
package ssh_df_pkg;

  localparam int unsigned MIN_BLOCK          = 8;
  localparam int unsigned MIN_PADDING        = 4;
  localparam int unsigned MAX_PADDING        = 255;
  localparam int unsigned DEFAULT_MAX_PACKET = 35000;

  // smallest legal length field: padding-length byte plus minimum padding
  localparam logic [31:0] MIN_LENGTH = 32'(1 + MIN_PADDING);

  // dividend for the alignment check is length + 4, which needs 33 bits
  localparam int unsigned DVD_W = 33;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_SIZE = 1'd1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_PADDING = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_PROTOCOL  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
  localparam logic [1:0] STATUS_BAD_BLOCK = 2'd3;

  typedef enum logic [2:0] {
    ST_LENGTH,
    ST_MODCHK,
    ST_PADLEN,
    ST_PAYLOAD,
    ST_PADDING,
    ST_HALT
  } state_t;

  // status of the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } mod_stat_t;

endpackage

FILE: sv/ssh_packet_deframer.sv
// ----------------------------------------------------------------------------
// ssh_packet_deframer
// Receive-side deframer for unencrypted ssh binary packets.
// ----------------------------------------------------------------------------
// Takes the packet stream one byte per beat, checks the big-endian length
// field and the padding-length byte, and emits payload then padding bytes;
// the final padding beat carries sequence number, lengths and status. Length
// bytes, padding-length byte, payload and padding bytes are taken back to back
// when the result side keeps up. After the fourth length byte the block
// checks alignment of length plus four to the block size with a bit-serial
// remainder unit: input is held off while it runs, and longer if a failed
// alignment check has to wait for the result slot. The first error is
// reported once with last set and then every following byte is swallowed
// until reset. Write the configuration only while idle.
module ssh_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ssh_df_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_wdata,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result beats out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [31:0] out_sequence_res,
  output logic [31:0] out_packet_length,
  output logic [7:0]  out_pad_len
);

  // configuration registers
  logic [7:0]  block_size_r;
  logic [31:0] max_packet_r;

  // control state
  ssh_df_pkg::state_t state_r, state_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] length_r, length_nxt;
  logic [7:0]  pad_cnt_r, pad_cnt_nxt;
  logic [7:0]  pad_len_r, pad_len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] seq_r, seq_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] oseq_r, oseq_nxt;
  logic [31:0] oplen_r, oplen_nxt;
  logic [7:0]  opadl_r, opadl_nxt;
  logic        out_load;

  // remainder unit hookup
  logic                         mod_start;
  logic [7:0]                   blk_eff;
  logic [31:0]                  maxp_eff;
  ssh_df_pkg::mod_stat_t        mod_stat;

  logic        in_fire;
  logic [31:0] len_shift;

  assign blk_eff  = (block_size_r == 8'd0) ? 8'(ssh_df_pkg::MIN_BLOCK) : block_size_r;
  assign maxp_eff = (max_packet_r == 32'd0) ? 32'(ssh_df_pkg::DEFAULT_MAX_PACKET)
                                            : max_packet_r;

  // output slot frees when it is empty or being drained this cycle
  assign in_ready = (state_r != ssh_df_pkg::ST_MODCHK) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign len_shift = {length_r[23:0], in_rx_byte};

  // dividend is the complete length field as it is being latched, plus four
  ssh_df_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend ({1'b0, len_shift} + ssh_df_pkg::DVD_W'(4)),
    .divisor  (blk_eff),
    .stat     (mod_stat)
  );

  always_comb begin
    state_nxt   = state_r;
    hdr_cnt_nxt = hdr_cnt_r;
    length_nxt  = length_r;
    pad_cnt_nxt = pad_cnt_r;
    pad_len_nxt = pad_len_r;
    left_nxt    = left_r;
    seq_nxt     = seq_r;
    mod_start   = 1'b0;
    out_load    = 1'b0;
    kind_nxt    = ssh_df_pkg::KIND_PAYLOAD;
    data_nxt    = 8'd0;
    last_nxt    = 1'b0;
    status_nxt  = ssh_df_pkg::STATUS_OK;
    oseq_nxt    = 32'd0;
    oplen_nxt   = 32'd0;
    opadl_nxt   = 8'd0;

    unique case (state_r)
      ssh_df_pkg::ST_LENGTH: begin
        if (in_fire) begin
          length_nxt = len_shift;
          if (hdr_cnt_r != 2'd3) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else begin
            hdr_cnt_nxt = 2'd0;
            // checks in fixed order: block size, minimum, maximum
            priority if (blk_eff < 8'(ssh_df_pkg::MIN_BLOCK) ||
                         9'(blk_eff) > 9'(ssh_df_pkg::MAX_PADDING)) begin
              out_load   = 1'b1;
              status_nxt = ssh_df_pkg::STATUS_BAD_BLOCK;
            end else if (len_shift < ssh_df_pkg::MIN_LENGTH) begin
              out_load   = 1'b1;
              status_nxt = ssh_df_pkg::STATUS_PROTOCOL;
            end else if (len_shift > maxp_eff) begin
              out_load   = 1'b1;
              status_nxt = ssh_df_pkg::STATUS_OVERFLOW;
            end else begin
              mod_start = 1'b1;
              state_nxt = ssh_df_pkg::ST_MODCHK;
            end
            if (out_load) begin
              kind_nxt  = ssh_df_pkg::KIND_ERROR;
              last_nxt  = 1'b1;
              oseq_nxt  = seq_r;
              oplen_nxt = len_shift;
              state_nxt = ssh_df_pkg::ST_HALT;
            end
          end
        end
      end

      ssh_df_pkg::ST_MODCHK: begin
        // unit starts on entry; a misalignment report waits for a free slot
        if (mod_stat.done) begin
          if (mod_stat.zero) begin
            state_nxt = ssh_df_pkg::ST_PADLEN;
          end else if (!out_valid_r || out_ready) begin
            out_load   = 1'b1;
            kind_nxt   = ssh_df_pkg::KIND_ERROR;
            last_nxt   = 1'b1;
            status_nxt = ssh_df_pkg::STATUS_PROTOCOL;
            oseq_nxt   = seq_r;
            oplen_nxt  = length_r;
            state_nxt  = ssh_df_pkg::ST_HALT;
          end
        end
      end

      ssh_df_pkg::ST_PADLEN: begin
        if (in_fire) begin
          if (in_rx_byte < 8'(ssh_df_pkg::MIN_PADDING) ||
              (33'(in_rx_byte) + 33'd1) > 33'(length_r)) begin
            out_load   = 1'b1;
            kind_nxt   = ssh_df_pkg::KIND_ERROR;
            last_nxt   = 1'b1;
            status_nxt = ssh_df_pkg::STATUS_PROTOCOL;
            oseq_nxt   = seq_r;
            oplen_nxt  = length_r;
            opadl_nxt  = in_rx_byte;
            state_nxt  = ssh_df_pkg::ST_HALT;
          end else begin
            pad_len_nxt = in_rx_byte;
            pad_cnt_nxt = in_rx_byte;
            left_nxt    = length_r - 32'(in_rx_byte) - 32'd1;
            // empty payload goes straight to padding
            state_nxt   = (left_nxt == 32'd0) ? ssh_df_pkg::ST_PADDING
                                              : ssh_df_pkg::ST_PAYLOAD;
          end
        end
      end

      ssh_df_pkg::ST_PAYLOAD: begin
        if (in_fire) begin
          out_load = 1'b1;
          kind_nxt = ssh_df_pkg::KIND_PAYLOAD;
          data_nxt = in_rx_byte;
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            state_nxt = ssh_df_pkg::ST_PADDING;
          end
        end
      end

      ssh_df_pkg::ST_PADDING: begin
        if (in_fire) begin
          out_load = 1'b1;
          kind_nxt = ssh_df_pkg::KIND_PADDING;
          data_nxt = in_rx_byte;
          if (pad_cnt_r <= 8'd1) begin
            // final padding byte closes the packet
            last_nxt    = 1'b1;
            oseq_nxt    = seq_r;
            oplen_nxt   = length_r;
            opadl_nxt   = pad_len_r;
            seq_nxt     = seq_r + 32'd1;
            pad_cnt_nxt = 8'd0;
            length_nxt  = 32'd0;
            state_nxt   = ssh_df_pkg::ST_LENGTH;
          end else begin
            pad_cnt_nxt = pad_cnt_r - 8'd1;
          end
        end
      end

      ssh_df_pkg::ST_HALT: begin
        // error latched: bytes are taken and dropped
      end

      default: begin
        state_nxt = ssh_df_pkg::ST_LENGTH;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // configuration writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= 8'd0;
      max_packet_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssh_df_pkg::CFG_BLOCK_SIZE:      block_size_r <= cfg_wdata[7:0];
        ssh_df_pkg::CFG_MAX_PACKET_SIZE: max_packet_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssh_df_pkg::ST_LENGTH;
      hdr_cnt_r   <= 2'd0;
      length_r    <= 32'd0;
      pad_cnt_r   <= 8'd0;
      pad_len_r   <= 8'd0;
      left_r      <= 32'd0;
      seq_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      length_r    <= length_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
      pad_len_r   <= pad_len_nxt;
      left_r      <= left_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only with a new beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
      oseq_r   <= oseq_nxt;
      oplen_r  <= oplen_nxt;
      opadl_r  <= opadl_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_data_byte      = data_r;
  assign out_last           = last_r;
  assign out_status         = status_r;
  assign out_sequence_res   = oseq_r;
  assign out_packet_length  = oplen_r;
  assign out_pad_len        = opadl_r;

endmodule

FILE: sv/ssh_df_mod.sv
// ----------------------------------------------------------------------------
// ssh_df_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ssh_df_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssh_df_pkg::DVD_W-1:0]  dividend,
  input  logic [7:0]                    divisor,
  output ssh_df_pkg::mod_stat_t         stat
);

  logic [ssh_df_pkg::CNT_W-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [7:0]                   rem_r;
  logic [7:0]                   rem_nxt;
  logic [7:0]                   dvs_r;
  logic [ssh_df_pkg::DVD_W-1:0] dvd_r;
  logic [8:0]                   trial;

  // shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    trial = {rem_r, dvd_r[ssh_df_pkg::DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = 8'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[7:0];
    end
  end

  // done stays up with the remainder until the next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= ssh_df_pkg::CNT_W'(ssh_df_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ssh_df_pkg::CNT_W'(1);
        if (cnt_r == ssh_df_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[ssh_df_pkg::DVD_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.zero = (rem_r == 8'd0);

endmodule
